[hdl/sjq_pkg.sv]
// Package for the scaled-Jacobian quality block: payload types, datapath widths and codes.
// Has no dependencies; all files but sjq_chan_if and sjq_mul use it by scoped names.
`default_nettype none

package sjq_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = CoordW + 1;   // coordinate difference, no wrap
  localparam int unsigned SqW    = 2 * DiffW;    // squared component and squared edge length
  localparam int unsigned CrossW = SqW + 1;      // signed cross-product component
  localparam int unsigned CMagW  = SqW;          // magnitude of a cross-product component
  localparam int unsigned TermW  = CMagW + DiffW;
  localparam int unsigned JSumW  = TermW + 2;
  localparam int unsigned RootW  = TermW;        // operand of the final squaring
  localparam int unsigned PairW  = 2 * SqW;
  localparam int unsigned DenW   = PairW + SqW;
  localparam int unsigned NumW   = DenW + 34;
  localparam int unsigned QualW  = 17;

  typedef logic [1:0] elem_dim_t;
  localparam elem_dim_t ElemDimTri   = 2'd2;
  localparam elem_dim_t ElemDimReset = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] vert0_x;
    logic signed [CoordW-1:0] vert0_y;
    logic signed [CoordW-1:0] vert0_z;
    logic signed [CoordW-1:0] vert1_x;
    logic signed [CoordW-1:0] vert1_y;
    logic signed [CoordW-1:0] vert1_z;
    logic signed [CoordW-1:0] vert2_x;
    logic signed [CoordW-1:0] vert2_y;
    logic signed [CoordW-1:0] vert2_z;
    logic signed [CoordW-1:0] vert3_x;
    logic signed [CoordW-1:0] vert3_y;
    logic signed [CoordW-1:0] vert3_z;
  } item_t;

  typedef struct packed {
    logic [QualW-1:0] quality;
  } result_t;

  // Hand-off from the geometry front end to the square-root search.
  typedef struct packed {
    logic            valid;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } ratio_t;

endpackage

`default_nettype wire

[hdl/sjq_chan_if.sv]
// Valid/ready channel interface used for the item, result and configuration ports.
// The payload type is a parameter; types come from sjq_pkg at the instantiation.
`default_nettype none

interface sjq_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/sjq_mul.sv]
// Pipelined unsigned multiplier built from 32x32 partial products, three register stages.
// Depends on nothing but its parameters; the front end instantiates it.
`default_nettype none

module sjq_mul #(
  parameter int unsigned WA = 66,
  parameter int unsigned WB = 66
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  output logic [WA+WB-1:0] p_o
);
  localparam int unsigned CW = 32;
  localparam int unsigned NA = (WA + CW - 1) / CW;
  localparam int unsigned NB = (WB + CW - 1) / CW;
  localparam int unsigned RW = NA * CW + CW;
  localparam int unsigned PW = WA + WB;

  logic [NA*CW-1:0] a_ext;
  logic [NB*CW-1:0] b_ext;
  logic [2*CW-1:0]  pp_q  [NB][NA];
  logic [RW-1:0]    row_d [NB];
  logic [RW-1:0]    row_q [NB];
  logic [PW-1:0]    sum_d;
  logic [PW-1:0]    p_q;

  assign a_ext = (NA*CW)'(a_i);
  assign b_ext = (NB*CW)'(b_i);

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_d[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_d[j] = row_d[j] + (RW'(pp_q[j][i]) << (i * CW));
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int j = 0; j < NB; j++) begin
      sum_d = sum_d + (PW'(row_q[j]) << (j * CW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NB; j++) begin
        for (int i = 0; i < NA; i++) begin
          pp_q[j][i] <= a_ext[i*CW +: CW] * b_ext[j*CW +: CW];
        end
        row_q[j] <= row_d[j];
      end
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[hdl/sjq_front.sv]
// Geometry front end: edges, squared lengths, cross and triple products, and the exact
// numerator and denominator of the squared quality. Uses sjq_pkg and sjq_mul.
`default_nettype none

module sjq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic            tri_i,
  input  sjq_pkg::item_t  item_i,
  output sjq_pkg::ratio_t ratio_o
);
  localparam int unsigned Depth = 14;
  localparam int unsigned EdgeTo   [6] = '{1, 2, 0, 3, 3, 3};
  localparam int unsigned EdgeFrom [6] = '{0, 1, 2, 0, 1, 2};
  localparam int unsigned PairA    [4] = '{0, 0, 1, 3};
  localparam int unsigned PairB    [4] = '{2, 1, 2, 4};

  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] tri_q;
  sjq_pkg::item_t   item0_q;

  logic signed [sjq_pkg::DiffW-1:0]  v      [4][3];
  logic signed [sjq_pkg::DiffW-1:0]  e1_q   [6][3];
  logic signed [sjq_pkg::DiffW-1:0]  a_d    [3];
  logic signed [sjq_pkg::DiffW-1:0]  b_d    [3];
  logic        [sjq_pkg::SqW-1:0]    sq2_q  [6][3];
  logic signed [sjq_pkg::SqW-1:0]    p2_q   [6];
  logic signed [sjq_pkg::DiffW-1:0]  e2_2_q [3];
  logic        [sjq_pkg::SqW-1:0]    l3_q   [6];
  logic signed [sjq_pkg::CrossW-1:0] x3_q   [3];
  logic signed [sjq_pkg::DiffW-1:0]  e2_3_q [3];
  logic        [sjq_pkg::SqW-1:0]    f_d    [4];
  logic        [sjq_pkg::SqW-1:0]    f4_q   [4];
  logic        [sjq_pkg::SqW-1:0]    f5_q   [4];
  logic        [sjq_pkg::SqW-1:0]    f6_q   [4];
  logic        [sjq_pkg::CMagW-1:0]  xm4_q  [3];
  logic        [sjq_pkg::DiffW-1:0]  em4_q  [3];
  logic        [2:0]                 sgn_q  [4];
  logic        [sjq_pkg::CMagW-1:0]  cd_q   [4];
  logic        [sjq_pkg::TermW-1:0]  jt     [3];
  logic signed [sjq_pkg::JSumW-1:0]  jsum_d;
  logic signed [sjq_pkg::JSumW-1:0]  jsum_q;
  logic        [sjq_pkg::RootW-1:0]  rt_q;
  logic        [sjq_pkg::PairW-1:0]  pr6    [4];
  logic        [sjq_pkg::DenW-1:0]   am9    [4];
  logic        [sjq_pkg::DenW-1:0]   sq12;
  logic        [sjq_pkg::DenW-1:0]   mx10_q [2];
  logic        [sjq_pkg::DenW-1:0]   mx11_q;
  logic        [sjq_pkg::DenW-1:0]   mx12_q;
  logic        [sjq_pkg::NumW-1:0]   num13_q;
  logic        [sjq_pkg::DenW-1:0]   den13_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], vld_i};
    end
  end

  always_comb begin
    v[0][0] = {item0_q.vert0_x[sjq_pkg::CoordW-1], item0_q.vert0_x};
    v[0][1] = {item0_q.vert0_y[sjq_pkg::CoordW-1], item0_q.vert0_y};
    v[0][2] = {item0_q.vert0_z[sjq_pkg::CoordW-1], item0_q.vert0_z};
    v[1][0] = {item0_q.vert1_x[sjq_pkg::CoordW-1], item0_q.vert1_x};
    v[1][1] = {item0_q.vert1_y[sjq_pkg::CoordW-1], item0_q.vert1_y};
    v[1][2] = {item0_q.vert1_z[sjq_pkg::CoordW-1], item0_q.vert1_z};
    v[2][0] = {item0_q.vert2_x[sjq_pkg::CoordW-1], item0_q.vert2_x};
    v[2][1] = {item0_q.vert2_y[sjq_pkg::CoordW-1], item0_q.vert2_y};
    v[2][2] = {item0_q.vert2_z[sjq_pkg::CoordW-1], item0_q.vert2_z};
    v[3][0] = {item0_q.vert3_x[sjq_pkg::CoordW-1], item0_q.vert3_x};
    v[3][1] = {item0_q.vert3_y[sjq_pkg::CoordW-1], item0_q.vert3_y};
    v[3][2] = {item0_q.vert3_z[sjq_pkg::CoordW-1], item0_q.vert3_z};
  end

  // Triangle edges e0, e1, e2 are the tetrahedron edges e1, e2, e0 in the plane.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      a_d[c] = tri_q[1] ? e1_q[1][c] : e1_q[0][c];
      b_d[c] = tri_q[1] ? e1_q[2][c] : e1_q[3][c];
    end
    for (int i = 0; i < 3; i++) begin
      f_d[i] = tri_q[3] ? sjq_pkg::SqW'(3) : l3_q[3 + i];
    end
    f_d[3] = tri_q[3] ? '0 : l3_q[5];
  end

  always_comb begin
    jsum_d = '0;
    for (int c = 0; c < 3; c++) begin
      if (sgn_q[3][c]) begin
        jsum_d = jsum_d - sjq_pkg::JSumW'(jt[c]);
      end else begin
        jsum_d = jsum_d + sjq_pkg::JSumW'(jt[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tri_q   <= {tri_q[Depth-2:0], tri_i};
      item0_q <= item_i;
      for (int k = 0; k < 6; k++) begin
        for (int c = 0; c < 3; c++) begin
          e1_q[k][c]  <= (tri_q[0] && c == 2) ? '0 : v[EdgeTo[k]][c] - v[EdgeFrom[k]][c];
          sq2_q[k][c] <= e1_q[k][c] * e1_q[k][c];
        end
        l3_q[k] <= sq2_q[k][0] + sq2_q[k][1] + sq2_q[k][2];
      end
      p2_q[0] <= a_d[1] * b_d[2];
      p2_q[1] <= a_d[2] * b_d[1];
      p2_q[2] <= a_d[2] * b_d[0];
      p2_q[3] <= a_d[0] * b_d[2];
      p2_q[4] <= a_d[0] * b_d[1];
      p2_q[5] <= a_d[1] * b_d[0];
      for (int c = 0; c < 3; c++) begin
        e2_2_q[c] <= e1_q[2][c];
        e2_3_q[c] <= e2_2_q[c];
        x3_q[c]   <= sjq_pkg::CrossW'(p2_q[2*c]) - sjq_pkg::CrossW'(p2_q[2*c+1]);
        xm4_q[c]  <= x3_q[c][sjq_pkg::CrossW-1] ? sjq_pkg::CMagW'(-x3_q[c])
                                               : sjq_pkg::CMagW'(x3_q[c]);
        em4_q[c]  <= e2_3_q[c][sjq_pkg::DiffW-1] ? sjq_pkg::DiffW'(-e2_3_q[c])
                                                : sjq_pkg::DiffW'(e2_3_q[c]);
        sgn_q[0][c] <= x3_q[c][sjq_pkg::CrossW-1] ^ e2_3_q[c][sjq_pkg::DiffW-1];
      end
      for (int i = 0; i < 4; i++) begin
        f4_q[i] <= f_d[i];
        f5_q[i] <= f4_q[i];
        f6_q[i] <= f5_q[i];
      end
      for (int s = 1; s < 4; s++) begin
        sgn_q[s] <= sgn_q[s-1];
        cd_q[s]  <= cd_q[s-1];
      end
      cd_q[0] <= xm4_q[2];
      jsum_q  <= jsum_d;
      if (tri_q[8]) begin
        rt_q <= sjq_pkg::RootW'(cd_q[3]);
      end else begin
        rt_q <= jsum_q[sjq_pkg::JSumW-1] ? sjq_pkg::RootW'(-jsum_q) : sjq_pkg::RootW'(jsum_q);
      end
      mx10_q[0] <= (am9[0] >= am9[1]) ? am9[0] : am9[1];
      mx10_q[1] <= (am9[2] >= am9[3]) ? am9[2] : am9[3];
      mx11_q    <= (mx10_q[0] >= mx10_q[1]) ? mx10_q[0] : mx10_q[1];
      mx12_q    <= mx11_q;
      if (tri_q[12]) begin
        den13_q <= mx12_q;
        num13_q <= {sq12, 34'b0};
      end else begin
        den13_q <= (mx12_q >= sq12) ? mx12_q : sq12;
        num13_q <= {1'b0, sq12, 33'b0};
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_pair
    sjq_mul #(.WA(sjq_pkg::SqW), .WB(sjq_pkg::SqW)) u_pair (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (l3_q[PairA[i]]),
      .b_i   (l3_q[PairB[i]]),
      .p_o   (pr6[i])
    );
    sjq_mul #(.WA(sjq_pkg::PairW), .WB(sjq_pkg::SqW)) u_vert (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (pr6[i]),
      .b_i   (f6_q[i]),
      .p_o   (am9[i])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_triple
    sjq_mul #(.WA(sjq_pkg::CMagW), .WB(sjq_pkg::DiffW)) u_term (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (xm4_q[c]),
      .b_i   (em4_q[c]),
      .p_o   (jt[c])
    );
  end

  sjq_mul #(.WA(sjq_pkg::RootW), .WB(sjq_pkg::RootW)) u_square (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (rt_q),
    .b_i   (rt_q),
    .p_o   (sq12)
  );

  assign ratio_o.valid = vld_q[Depth-1];
  assign ratio_o.num   = num13_q;
  assign ratio_o.den   = den13_q;

endmodule

`default_nettype wire

[hdl/sjq_root.sv]
// Bit-serial pipelined search for the largest r with r*r*den <= num, one result bit a stage.
// Uses sjq_pkg for the widths and the ratio hand-off type.
`default_nettype none

module sjq_root (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  sjq_pkg::ratio_t            ratio_i,
  output logic                       vld_o,
  output logic [sjq_pkg::QualW-1:0]  quality_o
);
  localparam int unsigned Steps = sjq_pkg::QualW;
  localparam int unsigned TrW   = sjq_pkg::NumW + 2;
  localparam int unsigned TW    = sjq_pkg::DenW + sjq_pkg::QualW;

  // rem is num - r*r*den, tacc is r*den.
  logic [Steps-1:0]            vld_q;
  logic [Steps-1:0]            dz_q;
  logic [sjq_pkg::NumW-1:0]    rem_q  [Steps];
  logic [TW-1:0]               tacc_q [Steps];
  logic [sjq_pkg::DenW-1:0]    den_q  [Steps];
  logic [sjq_pkg::QualW-1:0]   r_q    [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int unsigned B = Steps - 1 - s;
    logic                     vld_in;
    logic                     dz_in;
    logic [sjq_pkg::NumW-1:0] rem_in;
    logic [TW-1:0]            tacc_in;
    logic [sjq_pkg::DenW-1:0] den_in;
    logic [sjq_pkg::QualW-1:0] r_in;
    logic [TrW-1:0]           trial;

    if (s == 0) begin : g_first
      assign vld_in  = ratio_i.valid;
      assign dz_in   = (ratio_i.den == '0);
      assign rem_in  = ratio_i.num;
      assign tacc_in = '0;
      assign den_in  = ratio_i.den;
      assign r_in    = '0;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign dz_in   = dz_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign tacc_in = tacc_q[s-1];
      assign den_in  = den_q[s-1];
      assign r_in    = r_q[s-1];
    end

    assign trial = (TrW'(tacc_in) << (B + 1)) + (TrW'(den_in) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dz_q[s]  <= dz_in;
        den_q[s] <= den_in;
        if (TrW'(rem_in) >= trial) begin
          rem_q[s]  <= rem_in - trial[sjq_pkg::NumW-1:0];
          tacc_q[s] <= tacc_in + (TW'(den_in) << B);
          r_q[s]    <= r_in | (sjq_pkg::QualW'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          tacc_q[s] <= tacc_in;
          r_q[s]    <= r_in;
        end
      end
    end
  end

  assign vld_o     = vld_q[Steps-1];
  assign quality_o = dz_q[Steps-1] ? '0 : r_q[Steps-1];

endmodule

`default_nettype wire

[hdl/element_scaled_jacobian_quality.sv]
// Scaled-Jacobian quality of one triangle or tetrahedron per transaction.
// A result passes through the 14-stage geometry front end, the 17-stage square-root
// search and the output register. Throughput: one item per cycle while the skid stage
// is empty; the whole pipeline moves on a single enable.
// Reset: asynchronous, active low; clears all valid bits and sets element_dim to 3.
`default_nettype none

module element_scaled_jacobian_quality (
  input  logic       clk_i,
  input  logic       rst_ni,
  sjq_chan_if.sink   cfg_i,
  sjq_chan_if.sink   item_i,
  sjq_chan_if.source result_o
);

  // The configuration register is always ready. The user must write it only while idle;
  // not enforced. The mode is sampled per item at the input and travels with it.
  sjq_pkg::elem_dim_t dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= sjq_pkg::ElemDimReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      dim_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  // The pipeline advances whenever the skid stage is empty. The skid stage takes the one
  // result that can leave the pipeline while the output register is held by the sink, so
  // input acceptance depends only on a register and never on the sink's ready.
  logic                        en;
  logic                        skid_vld_q;
  logic                        out_vld_q;
  sjq_pkg::result_t            skid_q;
  sjq_pkg::result_t            out_q;
  sjq_pkg::ratio_t             ratio;
  logic                        pipe_vld;
  logic [sjq_pkg::QualW-1:0]   pipe_quality;
  logic                        out_take;

  assign en           = !skid_vld_q;
  assign item_i.ready = en;
  assign out_take     = out_vld_q && result_o.ready;

  // Front end: edge vectors, squared lengths, the signed volume or doubled area, and the
  // exact numerator and denominator of the squared, scaled quality.
  sjq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (item_i.valid && item_i.ready),
    .tri_i   (dim_q == sjq_pkg::ElemDimTri),
    .item_i  (item_i.data),
    .ratio_o (ratio)
  );

  // Back end: one result bit per stage, which also handles the saturation at the top of
  // the range and the zero result of a degenerate element.
  sjq_root u_root (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ratio_i   (ratio),
    .vld_o     (pipe_vld),
    .quality_o (pipe_quality)
  );

  // The pipeline's last stage is handed over only on a cycle in which it advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_take) begin
      out_vld_q <= pipe_vld;
    end else if (pipe_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_take) begin
      out_q.quality <= pipe_quality;
    end else begin
      skid_q.quality <= pipe_quality;
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

  // A result can sit in the skid stage only behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> out_vld_q)
    else $error("skid stage holds a result while the output register is empty");

  // Once the sink takes the output, the waiting skid result moves up in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   skid_vld_q && result_o.ready |=> out_vld_q && !skid_vld_q)
    else $error("skid result did not advance to the output register");

  // The skid stage fills only when the output register was full and not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(skid_vld_q) |-> $past(out_vld_q && !result_o.ready))
    else $error("skid stage filled while the output register could accept");

endmodule

`default_nettype wire

[dv/element_scaled_jacobian_quality_tb.sv]
// Self-checking testbench for element_scaled_jacobian_quality: random and directed elements
// in triangle and tetrahedron mode, checked against an exact wide-integer predictor.
// Depends on sjq_pkg, sjq_chan_if and element_scaled_jacobian_quality from the RTL.
`default_nettype none

module element_scaled_jacobian_quality_tb;

  localparam int unsigned QualMax    = 131071;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 325;
  localparam int unsigned HoldCycles  = 300;
  localparam int          Unit        = 65536;

  // Wide enough for every exact product the quality ratio needs.
  typedef logic signed [319:0] wide_t;

  logic clk_i;
  logic rst_ni;

  sjq_chan_if #(.T(sjq_pkg::elem_dim_t)) cfg_if ();
  sjq_chan_if #(.T(sjq_pkg::item_t))     item_if ();
  sjq_chan_if #(.T(sjq_pkg::result_t))   result_if ();

  element_scaled_jacobian_quality DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if.sink),
    .item_i  (item_if.sink),
    .result_o(result_if.source)
  );

  // Element type the block is currently configured for, updated once a
  // configuration transaction completes (only while the block is idle).
  sjq_pkg::elem_dim_t dim_shadow;

  sjq_pkg::item_t            pending_items[$];
  logic [sjq_pkg::QualW-1:0] quality_queue[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        pressure_go;
  logic        pressure_hold;
  int unsigned hold_left;

  int unsigned n_items, n_tri, n_tet, n_zero, n_checked, n_mismatch, n_sat;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("element_scaled_jacobian_quality_tb: done, errors");
    $finish;
  end

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor(sqrt(floor(num/den))), zero for a degenerate element, saturated at the top.
  function automatic logic [sjq_pkg::QualW-1:0] root_of_ratio(wide_t num, wide_t den);
    wide_t       quo;
    logic [63:0] r;
    if (den == 0) return '0;
    if (num >= (den <<< 34)) return sjq_pkg::QualW'(QualMax);
    quo = num / den;
    r = floor_sqrt(quo[63:0]);
    if (r > QualMax) return sjq_pkg::QualW'(QualMax);
    return r[sjq_pkg::QualW-1:0];
  endfunction

  // Exact scaled-Jacobian quality of one element.
  function automatic logic [sjq_pkg::QualW-1:0] element_quality(sjq_pkg::item_t it,
                                                                sjq_pkg::elem_dim_t dim);
    wide_t p[4][3];
    wide_t e[6][3];
    wide_t l[6];
    wide_t cr, pm, x0, x1, x2, j, m, a;
    int    ta[6];
    int    fa[6];
    p[0][0] = wide_t'($signed(it.vert0_x)); p[0][1] = wide_t'($signed(it.vert0_y));
    p[0][2] = wide_t'($signed(it.vert0_z)); p[1][0] = wide_t'($signed(it.vert1_x));
    p[1][1] = wide_t'($signed(it.vert1_y)); p[1][2] = wide_t'($signed(it.vert1_z));
    p[2][0] = wide_t'($signed(it.vert2_x)); p[2][1] = wide_t'($signed(it.vert2_y));
    p[2][2] = wide_t'($signed(it.vert2_z)); p[3][0] = wide_t'($signed(it.vert3_x));
    p[3][1] = wide_t'($signed(it.vert3_y)); p[3][2] = wide_t'($signed(it.vert3_z));
    if (dim == sjq_pkg::ElemDimTri) begin
      ta = '{2, 0, 1, 0, 0, 0};
      fa = '{1, 2, 0, 0, 0, 0};
    end else begin
      ta = '{1, 2, 0, 3, 3, 3};
      fa = '{0, 1, 2, 0, 1, 2};
    end
    for (int k = 0; k < 6; k++) begin
      for (int c = 0; c < 3; c++) e[k][c] = p[ta[k]][c] - p[fa[k]][c];
    end
    if (dim == sjq_pkg::ElemDimTri) begin
      // Only x and y take part; twice the area over the largest edge-length pair.
      for (int k = 0; k < 3; k++) l[k] = e[k][0] * e[k][0] + e[k][1] * e[k][1];
      cr = e[0][0] * e[1][1] - e[0][1] * e[1][0];
      if (cr < 0) cr = -cr;
      pm = l[0] * l[1];
      if (l[1] * l[2] > pm) pm = l[1] * l[2];
      if (l[0] * l[2] > pm) pm = l[0] * l[2];
      return root_of_ratio((cr * cr) <<< 34, pm * 3);
    end
    for (int k = 0; k < 6; k++) begin
      l[k] = e[k][0] * e[k][0] + e[k][1] * e[k][1] + e[k][2] * e[k][2];
    end
    x0 = e[0][1] * e[3][2] - e[0][2] * e[3][1];
    x1 = e[0][2] * e[3][0] - e[0][0] * e[3][2];
    x2 = e[0][0] * e[3][1] - e[0][1] * e[3][0];
    j = x0 * e[2][0] + x1 * e[2][1] + x2 * e[2][2];
    if (j < 0) j = -j;
    j = j * j;
    // Largest corner product of squared edge lengths, or the squared triple product.
    m = l[0] * l[2] * l[3];
    a = l[0] * l[1] * l[4]; if (a > m) m = a;
    a = l[1] * l[2] * l[5]; if (a > m) m = a;
    a = l[3] * l[4] * l[5]; if (a > m) m = a;
    if (j > m) m = j;
    return root_of_ratio(j <<< 33, m);
  endfunction

  function automatic sjq_pkg::item_t make_elem(int ax, int ay, int az, int bx, int by, int bz,
                                               int cx, int cy, int cz, int dx, int dy, int dz);
    sjq_pkg::item_t it;
    it.vert0_x = ax; it.vert0_y = ay; it.vert0_z = az;
    it.vert1_x = bx; it.vert1_y = by; it.vert1_z = bz;
    it.vert2_x = cx; it.vert2_y = cy; it.vert2_z = cz;
    it.vert3_x = dx; it.vert3_y = dy; it.vert3_z = dz;
    return it;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  function automatic int jitter(int amount);
    return int'($urandom_range(0, 2 * amount)) - amount;
  endfunction

  // Random element: mostly near-regular shapes with random scale, offset and noise,
  // the rest full-range noise, small boxes and degenerate (repeated vertex) shapes.
  function automatic sjq_pkg::item_t random_elem();
    sjq_pkg::item_t it;
    int    s, ox, oy, oz, n, kind;
    kind = $urandom_range(0, 9);
    s  = $urandom_range(1, 2000) * (Unit / 16);
    ox = jitter(32'h1000_0000); oy = jitter(32'h1000_0000); oz = jitter(32'h1000_0000);
    n  = $urandom_range(0, 1) ? s / 4 : s / 64;
    case (kind)
      0, 1: begin
        it = make_elem($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      2: begin
        it = make_elem(small_coord(), small_coord(), small_coord(), small_coord(),
                       small_coord(), small_coord(), small_coord(), small_coord(),
                       small_coord(), small_coord(), small_coord(), small_coord());
      end
      3: begin
        it = make_elem($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 1)) begin
          it.vert2_x = it.vert0_x; it.vert2_y = it.vert0_y; it.vert2_z = it.vert0_z;
        end else begin
          it.vert3_x = it.vert1_x; it.vert3_y = it.vert1_y; it.vert3_z = it.vert1_z;
        end
      end
      default: begin
        // Near-regular tetrahedron whose first three vertices project to a fair triangle.
        it = make_elem(ox + s + jitter(n), oy + s + jitter(n), oz + s + jitter(n),
                       ox + s + jitter(n), oy - s + jitter(n), oz - s + jitter(n),
                       ox - s + jitter(n), oy + jitter(n), oz - s + jitter(n),
                       ox - s + jitter(n), oy - s + jitter(n), oz + s + jitter(n));
      end
    endcase
    return it;
  endfunction

  // Appends one element to the stimulus queue.
  task automatic add_item(sjq_pkg::item_t it);
    pending_items = {pending_items, it};
  endtask

  // Item driver: offers pending items, holds an item until its transaction completes,
  // and records the expected quality of every accepted item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      item_if.data  <= '0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        quality_queue = {quality_queue, element_quality(item_if.data, dim_shadow)};
        n_items++;
        if (dim_shadow == sjq_pkg::ElemDimTri) n_tri++; else n_tet++;
      end
      if (item_if.valid && !item_if.ready) begin
        item_if.valid <= 1'b1;
      end else if (pending_items.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        item_if.valid <= 1'b1;
        item_if.data  <= pending_items.pop_front();
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the block fills and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left     <= HoldCycles;
      pressure_hold <= 1'b0;
    end else if (pressure_go && hold_left != 0) begin
      hold_left     <= hold_left - 1;
      pressure_hold <= (hold_left > 1);
    end else begin
      pressure_hold <= 1'b0;
    end
  end

  // Result monitor and random ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        n_checked++;
        if (quality_queue.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("unexpected result transaction: quality=%0d", result_if.data.quality);
          end
        end else begin
          logic [sjq_pkg::QualW-1:0] want;
          want = quality_queue.pop_front();
          if (want == 0) n_zero++;
          if (want == QualMax) n_sat++;
          if (result_if.data.quality !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("quality mismatch: expected %0d, got %0d", want,
                       result_if.data.quality);
            end
          end
        end
      end
      result_if.ready <= !pressure_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Wait until every item is accepted and every result has come back.
  task automatic drain();
    while (pending_items.size() != 0 || item_if.valid || quality_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_dim(sjq_pkg::elem_dim_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    dim_shadow = v;
  endtask

  initial begin
    sjq_pkg::elem_dim_t phase_dims[6];
    phase_dims = '{sjq_pkg::ElemDimTri, 2'd0, sjq_pkg::ElemDimTri, 2'd1,
                   sjq_pkg::ElemDimReset, sjq_pkg::ElemDimTri};
    n_items = 0; n_tri = 0; n_tet = 0; n_zero = 0; n_sat = 0;
    n_checked = 0; n_mismatch = 0;
    dim_shadow = sjq_pkg::ElemDimReset;
    send_idle_pct = 23;
    recv_idle_pct = 62;
    pressure_go = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = sjq_pkg::ElemDimReset;
    item_if.valid = 1'b0;
    item_if.data = '0;
    result_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Tetrahedra under the reset setting: degenerate, regular, right corner,
    // both orientations, flat, and the coordinate extremes.
    add_item(make_elem(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_item(make_elem(Unit, Unit, Unit, Unit, -Unit, -Unit,
                       -Unit, Unit, -Unit, -Unit, -Unit, Unit));
    add_item(make_elem(Unit, Unit, Unit, -Unit, Unit, -Unit,
                       Unit, -Unit, -Unit, -Unit, -Unit, Unit));
    add_item(make_elem(0, 0, 0, Unit, 0, 0, 0, Unit, 0, 0, 0, Unit));
    add_item(make_elem(0, 0, 0, Unit, 0, 0, 0, Unit, 0, Unit, Unit, 0));
    add_item(make_elem(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff));
    add_item(make_elem(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                       32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                       32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                       32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000));
    add_item(make_elem(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    add_item(make_elem(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_dim(phase_dims[ph]);
      if (ph == 2) begin
        send_idle_pct <= 62;
        recv_idle_pct <= 23;
      end else if (ph == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        pressure_go   <= 1'b1;
      end
      if (ph == 0) begin
        // Triangles: degenerate, near-equilateral, right, collinear, repeated vertex,
        // both orientations, one-LSB size and the extremes, one of them with z fields set.
        add_item(make_elem(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_item(make_elem(0, 0, 5, 2 * Unit, 0, -7, Unit, 113512, 9, 1, 2, 3));
        add_item(make_elem(0, 0, 0, 2 * Unit, 0, 0, Unit, -113512, 0, 0, 0, 0));
        add_item(make_elem(0, 0, 0, Unit, 0, 0, 0, Unit, 0, 0, 0, 0));
        add_item(make_elem(0, 0, 0, Unit, Unit, 0, 2 * Unit, 2 * Unit, 0, 0, 0, 0));
        add_item(make_elem(Unit, 3, 0, Unit, 3, 0, -Unit, 8, 0, 0, 0, 0));
        add_item(make_elem(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));
        add_item(make_elem(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                           32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                           32'sh8000_0000, 32'sh7fff_ffff, -1,
                           32'sh7fff_ffff, 32'sh8000_0000, -1));
        add_item(make_elem(32'sh7fff_ffff, 32'sh7fff_ffff, 0,
                           32'sh8000_0000, 32'sh7fff_ffff, 0,
                           32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0));
        add_item(make_elem(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      end
      for (int i = 0; i < PhaseItems; i++) add_item(random_elem());
      drain();
    end

    $display("covered %0d elements (%0d triangles, %0d tetrahedra) over 4 type codes;",
             n_items, n_tri, n_tet);
    $display("%0d results checked, %0d degenerate, %0d saturated, %0d mismatches",
             n_checked, n_zero, n_sat, n_mismatch);
    if (n_mismatch == 0 && quality_queue.size() == 0) begin
      $display("element_scaled_jacobian_quality_tb: done, clean");
    end else begin
      $display("element_scaled_jacobian_quality_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[element_scaled_jacobian_quality.f]
hdl/sjq_pkg.sv
hdl/sjq_chan_if.sv
hdl/sjq_mul.sv
hdl/sjq_front.sv
hdl/sjq_root.sv
hdl/element_scaled_jacobian_quality.sv
dv/element_scaled_jacobian_quality_tb.sv
